@@ hdl/spool_pkg.sv @@
// spool_pkg: shared types, sizes, command codes and helpers for the slot pool
// used by spool_ctrl, slot_pool_with_oldest_eviction_top and spool_chk
package spool_pkg;

  // pool sizing
  localparam int SLOT_COUNT     = 16;
  localparam int PARTICLE_LIMIT = 1024;

  localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int TIME_W  = 20;
  localparam int COUNT_W = 11;
  localparam int REQ_W   = 16;

  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [REQ_W-1:0]   LIMIT_REQ = REQ_W'(PARTICLE_LIMIT);
  localparam logic [REQ_W-1:0]   COUNT_MAX = REQ_W'({COUNT_W{1'b1}});

  // command codes
  localparam logic [1:0] CMD_SPAWN = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [REQ_W-1:0]  particle_count;
    logic [TIME_W-1:0] lifetime;
    logic [7:0]        material_id;
    logic [TIME_W-1:0] delta_time;
  } in_item_t;

  typedef struct packed {
    logic               slot_valid;
    logic [3:0]         slot_index;
    logic               evicted;
    logic [COUNT_W-1:0] stored_count;
    logic [4:0]         active_count;
  } out_item_t;

  // one memory word per slot
  typedef struct packed {
    logic [TIME_W-1:0]  age;
    logic [TIME_W-1:0]  lifetime;
    logic [COUNT_W-1:0] particles;
    logic [7:0]         material;
  } slot_entry_t;

  // write and read request toward the slot memory
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    slot_entry_t       wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // clamp a requested count to the limit and to the stored width
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [REQ_W-1:0] req);
    logic [REQ_W-1:0] n;
    n = req;
    if (n > LIMIT_REQ) n = LIMIT_REQ;
    if (n > COUNT_MAX) n = COUNT_MAX;
    return n[COUNT_W-1:0];
  endfunction

endpackage

@@ hdl/spool_ram.sv @@
// spool_ram: generic simple dual port memory, one write and one registered read
// no dependencies
module spool_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/spool_ctrl.sv @@
// spool_ctrl: command sequencer, active bits and memory scan for the slot pool
// depends on spool_pkg; drives the slot memory through spool_pkg::mem_req_t
module spool_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  spool_pkg::in_item_t    in_item,
  output logic                   res_valid,
  output spool_pkg::out_item_t   res_item,
  input  logic                   res_take,
  output spool_pkg::mem_req_t    mem_req,
  input  spool_pkg::slot_entry_t mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam int IDX_W = spool_pkg::IDX_W;
  localparam int PTR_W = IDX_W + 1;
  localparam logic [PTR_W-1:0] PTR_END  = PTR_W'(spool_pkg::SLOT_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(spool_pkg::SLOT_COUNT - 1);

  logic [1:0]                        state;
  logic [spool_pkg::SLOT_COUNT-1:0]  active;
  logic [spool_pkg::CNT_W-1:0]       act_cnt;
  logic [PTR_W-1:0]                  ptr;
  logic                              rd_pend;
  logic [IDX_W-1:0]                  rd_addr;
  spool_pkg::in_item_t               item;
  logic [IDX_W-1:0]                  best_idx;
  logic [spool_pkg::TIME_W-1:0]      best_age;
  logic                              r_valid;
  logic [IDX_W-1:0]                  r_idx;
  logic                              r_ev;
  logic [spool_pkg::COUNT_W-1:0]     r_cnt;

  logic                              accept;
  logic                              any_free;
  logic [IDX_W-1:0]                  free_idx;
  logic [spool_pkg::COUNT_W-1:0]     in_clamp;
  logic [spool_pkg::COUNT_W-1:0]     item_clamp;
  logic                              spawn_direct;
  logic                              scan_step;
  logic                              last;
  logic                              is_tick;
  logic [spool_pkg::TIME_W:0]        age_sum;
  logic [spool_pkg::TIME_W-1:0]      age_new;
  logic                              expire;
  logic                              is_better;
  logic [IDX_W-1:0]                  pick_idx;
  logic                              tick_wr;
  logic                              evict_wr;
  spool_pkg::in_item_t               src;

  assign accept    = in_valid && (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign any_free  = ~&active;
  assign in_clamp  = spool_pkg::clamp_count(in_item.particle_count);
  assign item_clamp = spool_pkg::clamp_count(item.particle_count);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = spool_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) free_idx = IDX_W'(i);
    end
  end

  assign spawn_direct = accept && (in_item.command == spool_pkg::CMD_SPAWN) &&
                        (in_item.particle_count != '0) && any_free;

  // scan pipeline: read data for rd_addr arrives while the next read goes out
  assign scan_step = (state == S_SCAN) && rd_pend;
  assign last      = scan_step && (rd_addr == IDX_LAST);
  assign is_tick   = (item.command == spool_pkg::CMD_TICK);

  // saturating age update and expiry test
  assign age_sum = {1'b0, mem_rdata.age} + {1'b0, item.delta_time};
  assign age_new = age_sum[spool_pkg::TIME_W] ? spool_pkg::TIME_MAX
                                              : age_sum[spool_pkg::TIME_W-1:0];
  assign expire  = (age_new >= mem_rdata.lifetime);

  // oldest slot search, ties to the lowest index
  assign is_better = (rd_addr == '0) || (mem_rdata.age > best_age);
  assign pick_idx  = is_better ? rd_addr : best_idx;

  assign tick_wr  = scan_step && is_tick && active[rd_addr];
  assign evict_wr = last && !is_tick;
  assign src      = spawn_direct ? in_item : item;

  // memory request
  always_comb begin
    mem_req.we    = spawn_direct || tick_wr || evict_wr;
    mem_req.raddr = ptr[IDX_W-1:0];
    if (tick_wr) begin
      mem_req.waddr          = rd_addr;
      mem_req.wdata.age      = age_new;
      mem_req.wdata.lifetime = mem_rdata.lifetime;
      mem_req.wdata.particles = mem_rdata.particles;
      mem_req.wdata.material = mem_rdata.material;
    end else begin
      mem_req.waddr          = spawn_direct ? free_idx : pick_idx;
      mem_req.wdata.age      = '0;
      mem_req.wdata.lifetime = src.lifetime;
      mem_req.wdata.particles = spawn_direct ? in_clamp : item_clamp;
      mem_req.wdata.material = src.material_id;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      active  <= '0;
      act_cnt <= '0;
      ptr     <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            ptr     <= '0;
            rd_pend <= 1'b0;
            case (in_item.command)
              spool_pkg::CMD_SPAWN: begin
                if (in_item.particle_count == '0) begin
                  state <= S_EMIT;
                end else if (any_free) begin
                  active[free_idx] <= 1'b1;
                  act_cnt          <= act_cnt + 1'b1;
                  state            <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              spool_pkg::CMD_TICK: begin
                state <= S_SCAN;
              end
              spool_pkg::CMD_CLEAR: begin
                active  <= '0;
                act_cnt <= '0;
                state   <= S_EMIT;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (ptr < PTR_END) ptr <= ptr + 1'b1;
          rd_pend <= (ptr < PTR_END);
          if (tick_wr && expire) begin
            active[rd_addr] <= 1'b0;
            act_cnt         <= act_cnt - 1'b1;
          end
          if (last) state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_take) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= in_item;
      r_valid <= spawn_direct;
      r_idx   <= spawn_direct ? free_idx : '0;
      r_ev    <= 1'b0;
      r_cnt   <= spawn_direct ? in_clamp : '0;
    end
    if (state == S_SCAN) begin
      rd_addr <= ptr[IDX_W-1:0];
    end
    if (scan_step && !is_tick) begin
      best_idx <= pick_idx;
      if (is_better) best_age <= mem_rdata.age;
    end
    if (evict_wr) begin
      r_valid <= 1'b1;
      r_idx   <= pick_idx;
      r_ev    <= 1'b1;
      r_cnt   <= item_clamp;
    end
  end

  // result toward the output register
  assign res_valid             = (state == S_EMIT);
  assign res_item.slot_valid   = r_valid;
  assign res_item.slot_index   = 4'(r_idx);
  assign res_item.evicted      = r_ev;
  assign res_item.stored_count = r_cnt;
  assign res_item.active_count = 5'(act_cnt);

endmodule

@@ hdl/slot_pool_with_oldest_eviction_top.sv @@
// slot_pool_with_oldest_eviction_top: slot pool top level with output register
// depends on spool_pkg, spool_ctrl and spool_ram
//
//   channel  | signals                       | direction
//   ---------+-------------------------------+----------
//   command  | in_valid, in_stall, in_item   | into block
//   result   | out_valid, out_stall, out_item| out of block
//
// one command is worked on at a time; a result goes out for every command
// spawn into a free slot, clear, no-op and zero-count spawn go straight to the result
// tick and evicting spawn first make one pass over the slot memory read port,
// one entry per cycle
// synchronous reset clears all active bits at once, no clearing pass
// the output register lets a new command start while a result is stalled
module slot_pool_with_oldest_eviction_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spool_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spool_pkg::out_item_t out_item
);

  logic                   res_valid;
  spool_pkg::out_item_t   res_item;
  logic                   res_take;
  spool_pkg::mem_req_t    mem_req;
  spool_pkg::slot_entry_t mem_rdata;

  spool_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_take  (res_take),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  spool_ram #(
    .WIDTH ($bits(spool_pkg::slot_entry_t)),
    .DEPTH (spool_pkg::SLOT_COUNT),
    .AW    (spool_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item <= res_item;
    end
  end

endmodule

@@ hdl/spool_chk.sv @@
// spool_chk: port-level checks for the slot pool, bound to the top level
// depends on spool_pkg
module spool_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input spool_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input logic                 out_stall,
  input spool_pkg::out_item_t out_item
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // one command at a time: after an accepted command the input stalls
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted while busy");

  // without an assigned slot the slot fields are zero
  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.slot_valid |->
      out_item.slot_index == '0 && !out_item.evicted && out_item.stored_count == '0)
    else $error("slot fields set without slot");

  // an assigned slot always holds particles and leaves the pool non-empty
  a_slot_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.slot_valid |->
      out_item.stored_count != '0 && out_item.active_count != '0)
    else $error("assigned slot with empty count");

endmodule

bind slot_pool_with_oldest_eviction_top spool_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
